// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg - shared definitions for the bounded array deque
// Widths, operation and status codes, and register map constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CAP_W         = 5;
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam int unsigned DEPTH_DEFAULT = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register index taken from the word address
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_INJECT = 2'd1;
  localparam logic [1:0] MODE_POP    = 2'd2;
  localparam logic [1:0] MODE_EJECT  = 2'd3;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_NO_FRONT = 2'd2;
  localparam logic [1:0] STS_EMPTY    = 2'd3;

endpackage

`default_nettype wire

// File: rtl/bounded_array_deque_unit.sv
// ----------------------------------------------------------------------------
// bounded_array_deque_unit - bounded deque kept in a linear slot array
// Push front, inject rear, pop front and eject rear, one word per operation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation word: mode_i
//   and value_i. Output channel (out_valid_o / out_stall_i) returns exactly one
//   word per operation: removed_value_o and status_o.
//   The APB port holds one register, capacity, at byte address 0.
// Result path (accept to output valid):
//   push, inject with free slot, any refused op, pop/eject on empty: result register loads at the accept edge.
//   pop / eject with data: through ST_READ (registered slot read), then the result register.
//   inject that compacts: ST_SHIFT once per live entry, then ST_FILL.
//   The single read and single write port of the slot RAM shapes this sequence:
//   compaction moves one entry per cycle through it.
// Throughput: one operation in flight; the next word is taken in the first
//   idle cycle once the previous result is gone or leaves at that same edge.
//   Unstalled, that is one word per cycle for push, inject and refused ops;
//   pop/eject with data and compaction hold new input until back in ST_IDLE.
// Reset: the deque is empty, both indices are 0, capacity is 16. Slot
//   contents are not cleared and need no clearing pass.
// Stall: a stalled result holds its word; the unit then refuses new input
//   until the result register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_deque_unit #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // operation input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       mode_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] value_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [bdq_pkg::DATA_W-1:0] removed_value_o,
  output logic [1:0]                       status_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bdq_pkg::PADDR_W-1:0]      paddr,
  input  logic [bdq_pkg::PDATA_W-1:0]      pwdata,
  output logic [bdq_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  import bdq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_FILL
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   tail_q, tail_d;
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic               empty_q, empty_d;
  logic [DATA_W-1:0]  item_q, item_d;
  logic               out_valid_q, out_valid_d;
  logic [DATA_W-1:0]  removed_q, removed_d;
  logic [1:0]         status_q, status_d;
  logic [CAP_W-1:0]   capacity_q;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  logic               in_accept;
  logic               cfg_write;
  logic [IDX_W-1:0]   lim;      // last usable slot
  logic               full;

  // --------------------------------------------------------------------------
  // Configuration port: always ready, capacity at word 0
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_write && paddr[2] == REG_CAPACITY) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  // Clamp capacity into 1..DEPTH and keep only the last usable index.
  always_comb begin
    if (capacity_q == '0) begin
      lim = '0;
    end else if (32'(capacity_q) > 32'(DEPTH)) begin
      lim = IDX_W'(DEPTH - 1);
    end else begin
      lim = IDX_W'(32'(capacity_q) - 32'd1);
    end
  end

  assign full = !empty_q && head_q == '0 && tail_q >= lim;

  // --------------------------------------------------------------------------
  // Handshakes: take a new word only in idle and only when the result
  // register is free by the next edge.
  // --------------------------------------------------------------------------
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign removed_value_o = removed_q;
  assign status_o    = status_q;

  // --------------------------------------------------------------------------
  // Sequencer: decide the operation at accept, then drive the slot RAM
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ptr_d       = ptr_q;
    empty_d     = empty_q;
    item_d      = item_q;
    out_valid_d = out_valid_q;
    removed_d   = removed_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_wdata   = value_i;
    ram_raddr   = head_q;

    // drop the result once the receiver takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          // default result: ok with nothing removed
          out_valid_d = 1'b1;
          removed_d   = '0;
          status_d    = STS_OK;
          case (mode_i)
            MODE_PUSH, MODE_INJECT: begin
              if (full) begin
                status_d = STS_FULL;
              end else if (empty_q) begin
                // first entry always lands in slot 0
                head_d    = '0;
                tail_d    = '0;
                empty_d   = 1'b0;
                ram_we    = 1'b1;
                ram_waddr = '0;
              end else if (mode_i == MODE_PUSH) begin
                if (head_q != '0) begin
                  head_d    = head_q - IDX_W'(1);
                  ram_we    = 1'b1;
                  ram_waddr = head_q - IDX_W'(1);
                end else begin
                  status_d = STS_NO_FRONT;
                end
              end else if (tail_q < lim) begin
                tail_d    = tail_q + IDX_W'(1);
                ram_we    = 1'b1;
                ram_waddr = tail_q + IDX_W'(1);
              end else begin
                // compact: shift head..tail down one slot, then store at tail
                out_valid_d = out_valid_q && out_stall_i;
                item_d      = value_i;
                ptr_d       = head_q;
                ram_raddr   = head_q;
                state_d     = ST_SHIFT;
              end
            end
            MODE_POP, MODE_EJECT: begin
              if (empty_q) begin
                status_d = STS_EMPTY;
              end else begin
                out_valid_d = out_valid_q && out_stall_i;
                ram_raddr   = (mode_i == MODE_POP) ? head_q : tail_q;
                state_d     = ST_READ;
                if (head_q == tail_q) begin
                  head_d  = '0;
                  tail_d  = '0;
                  empty_d = 1'b1;
                end else if (mode_i == MODE_POP) begin
                  head_d = head_q + IDX_W'(1);
                end else begin
                  tail_d = tail_q - IDX_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_READ: begin
        out_valid_d = 1'b1;
        removed_d   = ram_rdata;
        status_d    = STS_OK;
        state_d     = ST_IDLE;
      end

      ST_SHIFT: begin
        // read data belongs to ptr; move it one slot down
        ram_we    = 1'b1;
        ram_waddr = ptr_q - IDX_W'(1);
        ram_wdata = ram_rdata;
        if (ptr_q == tail_q) begin
          state_d = ST_FILL;
        end else begin
          ram_raddr = ptr_q + IDX_W'(1);
          ptr_d     = ptr_q + IDX_W'(1);
        end
      end

      ST_FILL: begin
        ram_we      = 1'b1;
        ram_waddr   = tail_q;
        ram_wdata   = item_q;
        head_d      = head_q - IDX_W'(1);
        out_valid_d = 1'b1;
        removed_d   = '0;
        status_d    = STS_OK;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      ptr_q       <= '0;
      empty_q     <= 1'b1;
      item_q      <= '0;
      out_valid_q <= 1'b0;
      removed_q   <= '0;
      status_q    <= STS_OK;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      ptr_q       <= ptr_d;
      empty_q     <= empty_d;
      item_q      <= item_d;
      out_valid_q <= out_valid_d;
      removed_q   <= removed_d;
      status_q    <= status_d;
    end
  end

  // --------------------------------------------------------------------------
  // Slot storage
  // --------------------------------------------------------------------------
  bdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_empty_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0 && tail_q == '0))
    else $error("empty deque with nonzero index");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> head_q <= tail_q)
    else $error("head beyond tail");

  a_shift_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHIFT |-> (head_q != '0 && ptr_q >= head_q && ptr_q <= tail_q))
    else $error("compaction pointer out of live range");

  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> (out_valid_q && state_q == ST_IDLE))
    else $error("slot read did not produce a result");

endmodule

`default_nettype wire

// File: rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram - generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
